### rtl/assert_macros.svh
// Assertion macros used by table_search_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/tse_pkg.sv
// Package with the types and constants of the table search engine.
`default_nettype none
package tse_pkg;
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LINEAR = 2'd1,
    OP_BINARY = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] entry_index;
    logic [31:0] entry_value;
    logic [31:0] search_key;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [13:0] position;
    logic [14:0] probes;
  } rsp_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;
endpackage
`default_nettype wire

### rtl/tse_fp_cmp.sv
// IEEE single-precision equal and less-than comparator on bit patterns.
`default_nettype none
module tse_fp_cmp (
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  output tse_pkg::cmp_t res_o
);
  logic a_nan, b_nan, both_zero;
  logic [31:0] ka, kb;

  assign a_nan     = (a_i[30:0] > 31'h7F80_0000);
  assign b_nan     = (b_i[30:0] > 31'h7F80_0000);
  assign both_zero = (a_i[30:0] == 31'd0) && (b_i[30:0] == 31'd0);
  assign ka        = a_i[31] ? ~a_i : {1'b1, a_i[30:0]};
  assign kb        = b_i[31] ? ~b_i : {1'b1, b_i[30:0]};

  always_comb begin
    res_o.eq = !a_nan && !b_nan && (both_zero || (a_i == b_i));
    res_o.lt = !a_nan && !b_nan && !both_zero && (ka < kb);
  end
endmodule
`default_nettype wire

### rtl/table_search_engine.sv
// Top level of the table search engine: table memory, sequencer, comparator.
//
// Usage: a request on req_* either writes one table entry (opcode write),
// or runs a linear or binary search over entries 0 .. entries_in_use-1.
// Searches return one response on rsp_*: found flag, position, probes.
// Write requests and the unused opcode return nothing.
// Configuration: cfg_valid_i/cfg_ready_o write entries_in_use; counts above
// TABLE_DEPTH are clamped. Write it only while the block is idle.
// Timing: a write or an unused-opcode request is taken while idle, and the
// block stays ready for the next request. A search probes one entry at a
// time: a registered memory read (ST_READ), then the shared comparator
// (ST_CMP). One request is in work at a time; req_ready_o is low from the
// acceptance of a search until its response is taken.
// Reset clears the sequencer and entries_in_use; table contents stay
// undefined until written. A stalled receiver holds the response register.
`default_nettype none
`include "assert_macros.svh"
module table_search_engine #(
  parameter int unsigned TABLE_DEPTH = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  tse_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output tse_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [14:0]   cfg_data_i
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;

  tse_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q;
  logic [31:0]     mem [TABLE_DEPTH];
  logic [31:0]     rd_q;
  logic [31:0]     key_q;
  logic            lin_q;
  // signed-free range: lo and hi kept one wider, hi+1 stored to avoid -1
  logic [CW-1:0]   lo_q, lo_d, hie_q, hie_d;
  logic [CW-1:0]   mid;
  logic [14:0]     probes_q, probes_d;
  tse_pkg::rsp_t   rsp_q, rsp_d;
  tse_pkg::cmp_t   cmp;
  logic            empty;

  // Clamp the configured count to the table size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if ({17'd0, cfg_data_i} > TABLE_DEPTH) count_q <= CW'(TABLE_DEPTH);
      else count_q <= CW'(cfg_data_i);
    end
  end
  assign cfg_ready_o = 1'b1;

  // Probe address: linear walks lo, binary takes the midpoint of [lo, hie).
  assign mid   = lin_q ? lo_q : CW'(lo_q + ((hie_q - lo_q - CW'(1)) >> 1));
  assign empty = lin_q ? (lo_q >= count_q) : (lo_q >= hie_q);

  always_ff @(posedge clk_i) begin
    if (state_q == tse_pkg::ST_IDLE && req_valid_i
        && req_i.opcode == tse_pkg::OP_WRITE
        && {18'd0, req_i.entry_index} < TABLE_DEPTH) begin
      mem[AW'(req_i.entry_index)] <= req_i.entry_value;
    end
    rd_q <= mem[mid[AW-1:0]];
  end

  tse_fp_cmp u_cmp (.a_i(rd_q), .b_i(key_q), .res_o(cmp));

  always_comb begin
    state_d  = state_q;
    unique case (state_q)
      tse_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.opcode == tse_pkg::OP_LINEAR || req_i.opcode == tse_pkg::OP_BINARY)
            state_d = tse_pkg::ST_READ;
        end
      end
      tse_pkg::ST_READ: state_d = empty ? tse_pkg::ST_OUT : tse_pkg::ST_CMP;
      tse_pkg::ST_CMP:  state_d = cmp.eq ? tse_pkg::ST_OUT : tse_pkg::ST_READ;
      tse_pkg::ST_OUT:  if (rsp_ready_i) state_d = tse_pkg::ST_IDLE;
      default:          state_d = tse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lo_d     = lo_q;
    hie_d    = hie_q;
    probes_d = probes_q;
    rsp_d    = rsp_q;
    unique case (state_q)
      tse_pkg::ST_IDLE: begin
        lo_d     = '0;
        hie_d    = count_q;
        probes_d = '0;
      end
      tse_pkg::ST_READ: begin
        if (empty) begin
          rsp_d.found    = 1'b0;
          rsp_d.position = '0;
          rsp_d.probes   = probes_q;
        end
      end
      tse_pkg::ST_CMP: begin
        probes_d = probes_q + 15'd1;
        if (cmp.eq) begin
          rsp_d.found    = 1'b1;
          rsp_d.position = 14'(mid);
          rsp_d.probes   = probes_q + 15'd1;
        end else if (lin_q || cmp.lt) begin
          lo_d = mid + CW'(1);
        end else begin
          hie_d = mid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the search key, search mode, search range, probe count and response.
  always_ff @(posedge clk_i) begin
    if (state_q == tse_pkg::ST_IDLE && req_valid_i) begin
      key_q <= req_i.search_key;
      lin_q <= (req_i.opcode == tse_pkg::OP_LINEAR);
    end
    lo_q     <= lo_d;
    hie_q    <= hie_d;
    probes_q <= probes_d;
    rsp_q    <= rsp_d;
  end

  assign req_ready_o = (state_q == tse_pkg::ST_IDLE);
  assign rsp_valid_o = (state_q == tse_pkg::ST_OUT);
  assign rsp_o       = rsp_q;

  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o, "response dropped")
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, rsp_valid_o, !req_ready_o, "request taken with response pending")
  `ASSERT_NEXT(a_probe_bound, clk_i, rst_ni, state_q == tse_pkg::ST_CMP, {1'b0, probes_q} <= (CW+1)'(count_q), "probe count exceeds range")
endmodule
`default_nettype wire

### test/table_search_engine_test.sv
`timescale 1ns / 100ps
// Testbench for the table search engine: writes, linear and binary searches.
`default_nettype none
module table_search_engine_test;

  localparam int unsigned DEPTH = 16384;
  localparam int unsigned STALL_LIMIT = 200000;

  // Expected search answers, built from a private copy of the table.
  class search_scoreboard;
    logic [31:0] entries[DEPTH];
    int unsigned covered;
    tse_pkg::rsp_t answers[$];
    int unsigned fails;

    function new();
      covered = 0;
      fails = 0;
    endfunction

    function bit is_nan(logic [31:0] x);
      return x[30:0] > 31'h7F800000;
    endfunction

    function bit is_zero(logic [31:0] x);
      return x[30:0] == 31'd0;
    endfunction

    function bit same_value(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (is_zero(a) && is_zero(b)) return 1'b1;
      return a == b;
    endfunction

    // Map non-NaN patterns onto unsigned order.
    function logic [31:0] rank(logic [31:0] x);
      return x[31] ? ~x : (x | 32'h80000000);
    endfunction

    function bit below(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (is_zero(a) && is_zero(b)) return 1'b0;
      return rank(a) < rank(b);
    endfunction

    function void set_count(logic [14:0] n);
      covered = (n > DEPTH) ? DEPTH : n;
    endfunction

    // Note an accepted request and queue the answer it should produce.
    function void note_request(tse_pkg::req_t r);
      tse_pkg::rsp_t a;
      int lo, hi, mid;
      a = '0;
      case (tse_pkg::opcode_e'(r.opcode))
        tse_pkg::OP_WRITE: begin
          entries[r.entry_index] = r.entry_value;
          return;
        end
        tse_pkg::OP_LINEAR: begin
          for (int i = 0; i < covered; i++) begin
            a.probes++;
            if (same_value(entries[14'(i)], r.search_key)) begin
              a.found = 1'b1;
              a.position = 14'(i);
              break;
            end
          end
        end
        tse_pkg::OP_BINARY: begin
          lo = 0;
          hi = int'(covered) - 1;
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            a.probes++;
            if (same_value(entries[14'(mid)], r.search_key)) begin
              a.found = 1'b1;
              a.position = 14'(mid);
              break;
            end
            if (below(entries[14'(mid)], r.search_key)) lo = mid + 1;
            else hi = mid - 1;
          end
        end
        default: return;
      endcase
      answers.push_back(a);
    endfunction

    function void check_answer(tse_pkg::rsp_t got);
      tse_pkg::rsp_t want;
      if (answers.size() == 0) begin
        $error("unexpected response found=%0d position=%0d probes=%0d",
               got.found, got.position, got.probes);
        fails++;
        return;
      end
      want = answers.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        fails++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        fails++;
      end
      if (got.probes !== want.probes) begin
        $error("probes: expected %0d, actual %0d", want.probes, got.probes);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  tse_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  tse_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  search_scoreboard board = new();
  int unsigned send_idle = 30;  // percent of cycles the sender holds off
  int unsigned recv_idle = 72;  // percent of cycles the receiver stalls
  int unsigned quiet = 0;

  always #5 clk_i = ~clk_i;

  table_search_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // Take responses, stall at random, and watch for a hung block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid && rsp_ready) board.check_answer(rsp);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
          (cfg_valid && cfg_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
    rsp_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Send one request; hold valid and payload until it is taken.
  task automatic push(tse_pkg::req_t r);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk_i); while (!req_ready);
    board.note_request(r);
  endtask

  task automatic push_op(tse_pkg::opcode_e op, logic [13:0] idx, logic [31:0] val,
                         logic [31:0] key);
    tse_pkg::req_t r;
    r.opcode = op;
    r.entry_index = idx;
    r.entry_value = val;
    r.search_key = key;
    push(r);
  endtask

  // Drop valid and wait until every answer is in, plus the write latency.
  task automatic drain();
    req_valid <= 1'b0;
    while (board.answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_entries(logic [14:0] n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_count(n);
  endtask

  // Fill 0..n-1 with ascending random patterns, cover them, then mix requests.
  task automatic random_phase(int unsigned n, int unsigned count);
    logic [31:0] ranks[$];
    logic [31:0] key;
    int unsigned pick;
    ranks = {};
    for (int i = 0; i < n; i++) ranks.push_back($urandom());
    ranks.sort();
    for (int i = 0; i < n; i++)
      push_op(tse_pkg::OP_WRITE, 14'(i),
              ranks[i][31] ? (ranks[i] & 32'h7FFFFFFF) : ~ranks[i], $urandom());
    set_entries(15'(n));
    for (int k = 0; k < count; k++) begin
      key = $urandom();
      if ($urandom_range(99) < 60) begin
        key = board.entries[14'($urandom_range(n - 1))];
        if (board.is_zero(key) || $urandom_range(9) == 0)
          key[31] = 1'($urandom_range(1));
      end
      pick = $urandom_range(99);
      if (pick < 50)
        push_op(tse_pkg::OP_BINARY, 14'($urandom()), $urandom(), key);
      else if (pick < 85)
        push_op(tse_pkg::OP_LINEAR, 14'($urandom()), $urandom(), key);
      else if (pick < 95)
        push_op(tse_pkg::OP_WRITE, 14'($urandom()), $urandom(), $urandom());
      else
        push_op(tse_pkg::OP_NONE, 14'($urandom()), $urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty range, unused opcode, signed zeros, infinities and NaN.
    set_entries(15'd0);
    push_op(tse_pkg::OP_LINEAR, '0, '0, 32'h00000000);
    push_op(tse_pkg::OP_BINARY, '1, '1, 32'hFFFFFFFF);
    push_op(tse_pkg::OP_NONE, '1, '1, '1);
    push_op(tse_pkg::OP_WRITE, 14'd0, 32'hFF800000, '0);
    push_op(tse_pkg::OP_WRITE, 14'd1, 32'hBF800000, '0);
    push_op(tse_pkg::OP_WRITE, 14'd2, 32'h80000000, '0);
    push_op(tse_pkg::OP_WRITE, 14'd3, 32'h3F800000, '0);
    push_op(tse_pkg::OP_WRITE, 14'd4, 32'h7F800000, '0);
    push_op(tse_pkg::OP_WRITE, 14'd5, 32'h7FC00000, '0);
    push_op(tse_pkg::OP_WRITE, 14'd16383, 32'hFFFFFFFF, '0);
    set_entries(15'd6);
    push_op(tse_pkg::OP_LINEAR, '0, '0, 32'h00000000);
    push_op(tse_pkg::OP_BINARY, '0, '0, 32'h00000000);
    push_op(tse_pkg::OP_BINARY, '0, '0, 32'h7F800000);
    push_op(tse_pkg::OP_BINARY, '0, '0, 32'hFF800000);
    push_op(tse_pkg::OP_LINEAR, '0, '0, 32'h7FC00000);
    push_op(tse_pkg::OP_BINARY, '0, '0, 32'hFFFFFFFF);
    push_op(tse_pkg::OP_LINEAR, '0, '0, 32'h3F800001);
    push_op(tse_pkg::OP_BINARY, '0, '0, 32'h3F800001);

    // Small tables under the three idling patterns.
    random_phase(1, 6);
    random_phase(4, 8);
    random_phase($urandom_range(3, 8), 8);
    send_idle = 72;
    recv_idle = 30;
    random_phase(2, 6);
    random_phase(5, 8);
    random_phase($urandom_range(3, 8), 8);
    send_idle = 0;
    recv_idle = 0;
    random_phase($urandom_range(3, 8), 8);

    drain();
    if (board.fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
